FILE: hdl/sync_word_8n1_frame_deframer_assert.svh
// assertion macros for the checker file
`ifndef SYNC_WORD_8N1_FRAME_DEFRAMER_ASSERT_SVH
`define SYNC_WORD_8N1_FRAME_DEFRAMER_ASSERT_SVH

// condition in the cycle after the trigger, off during reset
`define SW8N1_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// condition on the cycle after a reset edge
`define SW8N1_ASSERT_RESET(lbl, clk, rstn, cons, msg) \
    lbl: assert property (@(posedge clk) !(rstn) |=> (cons)) else $error(msg);

`endif

FILE: hdl/sw8n1_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sw8n1_pkg;

    // parameter defaults
    localparam int SYNC_BITS_DEF   = 20;
    localparam int FRAME_CHARS_DEF = 51;
    localparam int MAX_RUN_DEF     = 15;

    // fixed character format and limits
    localparam int CHAR_BITS = 10;
    localparam int FLUSH_CAP = 19;
    localparam int RUN_W     = 4;
    localparam int BYTE_W    = 8;
    localparam int SYNC_W    = 20;
    localparam int FLUSH_W   = 9;
    localparam int CFG_W     = 20;
    localparam int CFG_IDX_W = 2;
    localparam int S_DATA_W  = 8;
    localparam int M_DATA_W  = 8;
    localparam int M_USER_W  = 2;

    localparam logic [BYTE_W-1:0] DROP_BYTE = 8'hAA;
    localparam logic [3:0]        POS_STOP  = 4'(CHAR_BITS - 1);

    // register reset values
    localparam logic [SYNC_W-1:0]  RST_SYNC  = 20'd175275;
    localparam logic               RST_AUTO  = 1'b0;
    localparam logic               RST_INV   = 1'b0;
    localparam logic [FLUSH_W-1:0] RST_FLUSH = 9'd320;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYNC  = 2'd0,
        CFG_AUTO  = 2'd1,
        CFG_INV   = 2'd2,
        CFG_FLUSH = 2'd3
    } t_cfg_idx;

    // control into the frame assembler
    typedef struct packed {
        logic step;
        logic bit_val;
        logic start;
        logic flush;
    } t_frm_ctl;

    // status out of the frame assembler
    typedef struct packed {
        logic              in_frame;
        logic              emit_due;
        logic [BYTE_W-1:0] byte_val;
        logic              last;
        logic              keep;
        logic              over_thr;
    } t_frm_sts;

    // sync matcher result for the next window
    typedef struct packed {
        logic hit;
        logic inv_hit;
    } t_sync_sts;

endpackage
`default_nettype wire

FILE: hdl/sw8n1_sync.sv
`timescale 1ns / 1ps
`default_nettype none
module sw8n1_sync #(
    parameter int SYNC_BITS = sw8n1_pkg::SYNC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_shift,
    input  logic                         i_bit,
    input  logic                         i_auto,
    input  logic [sw8n1_pkg::SYNC_W-1:0] i_pattern,
    output sw8n1_pkg::t_sync_sts         o_sts
);
    import sw8n1_pkg::*;

    localparam int FW = $clog2(SYNC_BITS + 1);
    localparam logic [FW-1:0] FILL_FULL = FW'(SYNC_BITS);

    logic [SYNC_BITS-1:0]        r_win;
    logic [SYNC_BITS-1:0]        n_win;
    logic [FW-1:0]               r_fill;
    logic [FW-1:0]               n_fill;
    logic [SYNC_BITS+SYNC_W-1:0] w_pat_x;
    logic [SYNC_BITS-1:0]        w_pat;
    logic                        w_full;

    // pattern fitted to the window width
    assign w_pat_x = {{SYNC_BITS{1'b0}}, i_pattern};
    assign w_pat   = w_pat_x[SYNC_BITS-1:0];

    // window after this bit, oldest bit at the top
    assign n_win  = {r_win[SYNC_BITS-2:0], i_bit};
    assign n_fill = (r_fill == FILL_FULL) ? r_fill : r_fill + 1'b1;
    assign w_full = (n_fill == FILL_FULL);

    // match on the shifted window
    assign o_sts.hit     = w_full && (n_win == w_pat);
    assign o_sts.inv_hit = i_auto && w_full && (n_win == ~w_pat);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win  <= '0;
            r_fill <= '0;
        end else if (i_shift) begin
            r_win  <= n_win;
            r_fill <= n_fill;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/sw8n1_frame.sv
`timescale 1ns / 1ps
`default_nettype none
module sw8n1_frame #(
    parameter int FRAME_CHARS = sw8n1_pkg::FRAME_CHARS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sw8n1_pkg::t_frm_ctl           i_ctl,
    input  logic [sw8n1_pkg::FLUSH_W-1:0] i_flush_min,
    output sw8n1_pkg::t_frm_sts           o_sts
);
    import sw8n1_pkg::*;

    localparam int FRAME_LEN  = FRAME_CHARS * CHAR_BITS;
    localparam int FBW        = $clog2(FRAME_LEN);
    localparam int CMP_W      = (FBW > FLUSH_W) ? FBW : FLUSH_W;
    localparam int CW         = $clog2(FRAME_CHARS);
    localparam int FLOOR      = (FRAME_CHARS > FLUSH_CAP) ?
                                (FRAME_CHARS - FLUSH_CAP) * CHAR_BITS - 1 : 0;
    localparam logic [CMP_W-1:0] FLOOR_V   = CMP_W'(FLOOR);
    localparam logic [CW-1:0]    LAST_CHAR = CW'(FRAME_CHARS - 1);

    logic              r_in_frame;
    logic              r_sent;
    logic [FBW-1:0]    r_fbc;
    logic [3:0]        r_pos;
    logic [CW-1:0]     r_char;
    logic [BYTE_W-1:0] r_data;

    logic [CMP_W-1:0]  w_fbc_x;
    logic [CMP_W-1:0]  w_min_x;
    logic [CMP_W-1:0]  w_thr;
    logic              w_last;
    logic              w_keep;
    logic [2:0]        w_idx;

    // flush threshold with its floor
    assign w_fbc_x = CMP_W'(r_fbc);
    assign w_min_x = CMP_W'(i_flush_min);
    assign w_thr   = (w_min_x < FLOOR_V) ? FLOOR_V : w_min_x;

    assign w_last = (r_char == LAST_CHAR);
    assign w_keep = r_sent || (r_data != DROP_BYTE);
    assign w_idx  = 3'(r_pos - 4'd1);

    assign o_sts.in_frame = r_in_frame;
    assign o_sts.emit_due = r_in_frame && (r_pos == POS_STOP);
    assign o_sts.byte_val = r_data;
    assign o_sts.last     = w_last;
    assign o_sts.keep     = w_keep;
    assign o_sts.over_thr = r_in_frame && (w_fbc_x > w_thr);

    // character assembly, one bit per step, one slot per flush step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_sent     <= 1'b0;
            r_fbc      <= '0;
            r_pos      <= '0;
            r_char     <= '0;
            r_data     <= '0;
        end else if (i_ctl.start) begin
            r_in_frame <= 1'b1;
            r_sent     <= 1'b0;
            r_fbc      <= '0;
            r_pos      <= '0;
            r_char     <= '0;
            r_data     <= '0;
        end else if (i_ctl.step && r_in_frame) begin
            r_fbc <= r_fbc + 1'b1;
            if (r_pos == POS_STOP) begin
                r_pos  <= '0;
                r_data <= '0;
                if (w_keep) begin
                    r_sent <= 1'b1;
                end
                if (w_last) begin
                    r_in_frame <= 1'b0;
                    r_sent     <= 1'b0;
                    r_fbc      <= '0;
                    r_char     <= '0;
                end else begin
                    r_char <= r_char + 1'b1;
                end
            end else begin
                r_pos <= r_pos + 1'b1;
                if (r_pos inside {[4'd1:4'd8]}) begin
                    r_data[w_idx] <= i_ctl.bit_val;
                end
            end
        end else if (i_ctl.flush) begin
            r_data <= '0;
            if (w_keep) begin
                r_sent <= 1'b1;
            end
            if (w_last) begin
                r_in_frame <= 1'b0;
                r_sent     <= 1'b0;
                r_fbc      <= '0;
                r_pos      <= '0;
                r_char     <= '0;
            end else begin
                r_char <= r_char + 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

FILE: hdl/sync_word_8n1_frame_deframer.sv
// a run of n bits is accepted while idle, then shifted one bit per cycle unless the output stalls
// a data byte is in the output register the cycle after its stop bit is shifted
// input ready only while idle: a new run is taken once the last is shifted or flushed
// the bit-serial shifters take one bit per cycle; output stalls hold them
// synchronous active-low reset: searching for sync, window empty, registers at defaults
`timescale 1ns / 1ps
`default_nettype none
module sync_word_8n1_frame_deframer #(
    parameter int SYNC_BITS   = sw8n1_pkg::SYNC_BITS_DEF,
    parameter int FRAME_CHARS = sw8n1_pkg::FRAME_CHARS_DEF,
    parameter int MAX_RUN     = sw8n1_pkg::MAX_RUN_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // slave side
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [sw8n1_pkg::S_DATA_W-1:0]  i_s_tdata,  // line_level, run_bits[3:0]
    // master side
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [sw8n1_pkg::M_DATA_W-1:0]  o_m_tdata,  // byte_value[7:0]
    output logic                            o_m_tlast,  // last_in_frame
    output logic [sw8n1_pkg::M_USER_W-1:0]  o_m_tuser,  // cut_short, polarity_now
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [sw8n1_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [sw8n1_pkg::CFG_W-1:0]     i_cfg_data
);
    import sw8n1_pkg::*;

    localparam int RUN_LIM = (MAX_RUN < 15) ? MAX_RUN : 15;
    localparam logic [RUN_W-1:0] RUN_LIM_V = RUN_W'(RUN_LIM);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_RUN   = 3'b010,
        ST_FLUSH = 3'b100
    } t_state;

    t_state             r_state;
    t_state             n_state;
    logic [RUN_W-1:0]   r_cnt;
    logic               r_bit;
    logic               r_pol;
    logic [SYNC_W-1:0]  r_sync;
    logic               r_auto;
    logic [FLUSH_W-1:0] r_flush;

    logic               r_m_valid;
    logic [BYTE_W-1:0]  r_m_byte;
    logic               r_m_last;
    logic               r_m_cut;
    logic               r_m_pol;

    logic [RUN_W-1:0]   w_run_raw;
    logic [RUN_W-1:0]   w_run;
    logic               w_in_acc;
    logic               w_out_free;
    logic               w_step;
    logic               w_fstep;
    logic               w_flip;
    logic               w_emit;

    t_frm_ctl           w_ctl;
    t_frm_sts           w_sts;
    t_sync_sts          w_sync;

    // input fields with run length clamp
    assign w_run_raw = i_s_tdata[RUN_W:1];
    assign w_run     = (w_run_raw > RUN_LIM_V) ? RUN_LIM_V : w_run_raw;

    // handshake and step enables
    assign o_s_tready = (r_state == ST_IDLE);
    assign w_in_acc   = i_s_tvalid && (r_state == ST_IDLE);
    assign w_out_free = !r_m_valid || i_m_tready;
    assign w_step     = (r_state == ST_RUN) && !(w_sts.emit_due && !w_out_free);
    assign w_fstep    = (r_state == ST_FLUSH) && w_out_free;

    // frame start on sync, polarity flip on inverted sync
    assign w_ctl.step    = w_step;
    assign w_ctl.bit_val = r_bit;
    assign w_ctl.start   = w_step && !w_sts.in_frame && (w_sync.hit || w_sync.inv_hit);
    assign w_ctl.flush   = w_fstep;
    assign w_flip        = w_step && !w_sts.in_frame && !w_sync.hit && w_sync.inv_hit;
    assign w_emit        = ((w_step && w_sts.emit_due) || w_fstep) && w_sts.keep;

    sw8n1_sync #(
        .SYNC_BITS (SYNC_BITS)
    ) u_sync (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_shift   (w_step),
        .i_bit     (r_bit),
        .i_auto    (r_auto),
        .i_pattern (r_sync),
        .o_sts     (w_sync)
    );

    sw8n1_frame #(
        .FRAME_CHARS (FRAME_CHARS)
    ) u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .i_flush_min (r_flush),
        .o_sts       (w_sts)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (w_run == '0) begin
                        if (w_sts.over_thr) begin
                            n_state = ST_FLUSH;
                        end
                    end else begin
                        n_state = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                if (w_step && (r_cnt == 4'd1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_FLUSH: begin
                if (w_fstep && w_sts.last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state, run counter, polarity and registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_bit   <= 1'b0;
            r_pol   <= RST_INV;
            r_sync  <= RST_SYNC;
            r_auto  <= RST_AUTO;
            r_flush <= RST_FLUSH;
        end else begin
            r_state <= n_state;
            if (w_in_acc) begin
                r_cnt <= w_run;
                r_bit <= i_s_tdata[0] ^ r_pol;
            end else if (w_step) begin
                r_cnt <= r_cnt - 1'b1;
            end
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_SYNC:  r_sync  <= i_cfg_data[SYNC_W-1:0];
                    CFG_AUTO:  r_auto  <= i_cfg_data[0];
                    CFG_INV:   r_pol   <= i_cfg_data[0];
                    CFG_FLUSH: r_flush <= i_cfg_data[FLUSH_W-1:0];
                    default:   r_auto  <= r_auto;
                endcase
            end else if (w_flip) begin
                r_pol <= ~r_pol;
            end
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_emit) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_m_byte <= w_sts.byte_val;
            r_m_last <= w_sts.last;
            r_m_cut  <= w_fstep;
            r_m_pol  <= r_pol;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_byte;
    assign o_m_tlast  = r_m_last;
    assign o_m_tuser  = {r_m_pol, r_m_cut};

endmodule
`default_nettype wire

FILE: hdl/sw8n1_chk.sv
`timescale 1ns / 1ps
`default_nettype none
`include "sync_word_8n1_frame_deframer_assert.svh"
module sw8n1_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_s_tvalid,
    input logic                           o_s_tready,
    input logic [sw8n1_pkg::S_DATA_W-1:0] i_s_tdata,
    input logic                           o_m_tvalid,
    input logic                           i_m_tready,
    input logic [sw8n1_pkg::M_DATA_W-1:0] o_m_tdata,
    input logic                           o_m_tlast,
    input logic [sw8n1_pkg::M_USER_W-1:0] o_m_tuser
);
    // a stalled output item holds
    `SW8N1_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast) && $stable(o_m_tuser), "output item changed while stalled")

    // a run with bits keeps the input side busy for its shifting
    `SW8N1_ASSERT_NEXT(a_run_busy, i_clk, i_rst_n, i_s_tvalid && o_s_tready && (i_s_tdata[4:1] != 4'd0), !o_s_tready, "input ready right after a nonempty run")

    // reset empties the output and opens the input
    `SW8N1_ASSERT_RESET(a_reset_state, i_clk, i_rst_n, !o_m_tvalid && o_s_tready, "bad state after reset")

endmodule

bind sync_word_8n1_frame_deframer sw8n1_chk u_sw8n1_chk (.*);
`default_nettype wire

FILE: bench/tb.sv
`timescale 1ns / 1ps
module tb;
    import sw8n1_pkg::*;

    localparam int FRAME_CHARS  = FRAME_CHARS_DEF;
    localparam int FRAME_LEN    = FRAME_CHARS * CHAR_BITS;
    localparam int FLUSH_FLOOR  = (FRAME_CHARS - FLUSH_CAP) * CHAR_BITS - 1;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int PHASE_RUNS   = 95;
    localparam int N_PHASES     = 5;

    // one decoded byte as the block should deliver it
    typedef struct {
        logic [BYTE_W-1:0] value;
        logic              is_last;
        logic              cut;
        logic              pol;
    } deframer_byte_t;

    // tracks deframer state and the bytes still owed by the block
    class byte_tracker;
        logic [SYNC_W-1:0]  sync_word;
        logic               auto_pol;
        logic               inv_reset;
        logic [FLUSH_W-1:0] flush_min;
        logic [SYNC_W-1:0]  window;
        int                 fill;
        bit                 framing;
        int                 bit_cnt;
        logic [BYTE_W-1:0]  shift;
        logic               pol;
        bit                 sent;
        deframer_byte_t     bytes_due[$];
        int                 errors;
        int                 checked;
        int                 frames_done;
        int                 flushes;
        int                 syncs_inv;

        function new();
            sync_word   = RST_SYNC;
            auto_pol    = RST_AUTO;
            inv_reset   = RST_INV;
            flush_min   = RST_FLUSH;
            window      = '0;
            fill        = 0;
            pol         = RST_INV;
            errors      = 0;
            checked     = 0;
            frames_done = 0;
            flushes     = 0;
            syncs_inv   = 0;
            drop_frame();
        endfunction

        function void drop_frame();
            framing = 0;
            bit_cnt = 0;
            shift   = '0;
            sent    = 0;
        endfunction

        // leading 0xaa bytes of a frame are swallowed
        function bit push_byte(logic [BYTE_W-1:0] v, bit is_last, bit cut);
            deframer_byte_t rec;
            if (!sent && v == DROP_BYTE) return 0;
            sent        = 1;
            rec.value   = v;
            rec.is_last = is_last;
            rec.cut     = cut;
            rec.pol     = pol;
            bytes_due.push_back(rec);
            return 1;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_SYNC: sync_word = val[SYNC_W-1:0];
                CFG_AUTO: auto_pol = val[0];
                CFG_INV: begin
                    inv_reset = val[0];
                    pol       = val[0];
                end
                CFG_FLUSH: flush_min = val[FLUSH_W-1:0];
                default: ;
            endcase
        endfunction

        // accepted run: update state and queue the bytes it releases
        function void note_run(logic level, logic [RUN_W-1:0] run);
            int   n;
            int   c;
            int   first_slot;
            int   thr;
            int   pos;
            int   len;
            logic b;
            b   = level ^ pol;
            len = run;
            if (len > MAX_RUN_DEF) len = MAX_RUN_DEF;
            if (run == 0) begin
                // glitch past the threshold pads out the frame
                thr = (flush_min < FLUSH_FLOOR) ? FLUSH_FLOOR : int'(flush_min);
                if (framing && bit_cnt > thr) begin
                    n          = 0;
                    first_slot = bit_cnt / CHAR_BITS;
                    for (c = first_slot; c < FRAME_CHARS && n < FLUSH_CAP; c++)
                        n += push_byte((c == first_slot) ? shift : 8'h00,
                                       c == FRAME_CHARS - 1, 1'b1);
                    flushes++;
                    drop_frame();
                end
            end else begin
                for (int i = 0; i < len; i++) begin
                    window = {window[SYNC_W-2:0], b};
                    if (fill < SYNC_W) fill++;
                    if (!framing) begin
                        // sync search, inverted word only in auto mode
                        if (fill >= SYNC_W) begin
                            if (window == sync_word) begin
                                drop_frame();
                                framing = 1;
                            end else if (auto_pol && window == ~sync_word) begin
                                drop_frame();
                                framing = 1;
                                pol     = ~pol;
                                syncs_inv++;
                            end
                        end
                    end else begin
                        // 8n1 character assembly
                        pos = bit_cnt % CHAR_BITS;
                        c   = bit_cnt / CHAR_BITS;
                        if (pos >= 1 && pos <= 8) shift[pos-1] = shift[pos-1] | b;
                        bit_cnt++;
                        if (pos == CHAR_BITS - 1) begin
                            void'(push_byte(shift, c == FRAME_CHARS - 1, 1'b0));
                            shift = '0;
                        end
                        if (bit_cnt >= FRAME_LEN) begin
                            drop_frame();
                            frames_done++;
                        end
                    end
                end
            end
        endfunction

        function void check_byte(logic [BYTE_W-1:0] d, logic is_last,
                                 logic [M_USER_W-1:0] user);
            deframer_byte_t exp_b;
            checked++;
            if (bytes_due.size() == 0) begin
                $error("byte %02h arrived with nothing expected", d);
                errors++;
                return;
            end
            exp_b = bytes_due.pop_front();
            if (d !== exp_b.value) begin
                $error("byte_value: expected %02h, got %02h", exp_b.value, d);
                errors++;
            end
            if (is_last !== exp_b.is_last) begin
                $error("last_in_frame: expected %0b, got %0b", exp_b.is_last, is_last);
                errors++;
            end
            if (user[0] !== exp_b.cut) begin
                $error("cut_short: expected %0b, got %0b", exp_b.cut, user[0]);
                errors++;
            end
            if (user[1] !== exp_b.pol) begin
                $error("polarity_now: expected %0b, got %0b", exp_b.pol, user[1]);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [S_DATA_W-1:0]   i_s_tdata  = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [M_DATA_W-1:0]   o_m_tdata;
    logic                  o_m_tlast;
    logic [M_USER_W-1:0]   o_m_tuser;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_W-1:0]      i_cfg_data = '0;

    byte_tracker sb;
    bit          bit_seq[$];
    int unsigned s_idle_pct = 30;
    int unsigned m_idle_pct = 30;
    int          m_stall    = 0;
    int          runs_sent  = 0;
    int          run_limit  = 0;
    int          cycles     = 0;

    sync_word_8n1_frame_deframer u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // run timeout
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("sync_word_8n1_frame_deframer regression: fail");
            $finish;
        end
    end

    // receiver stalls in bursts
    always @(posedge i_clk) begin
        if (m_stall > 0) begin
            m_stall--;
            i_m_tready <= 1'b0;
        end else if (m_idle_pct != 0 && $urandom_range(0, 99) < m_idle_pct) begin
            m_stall = $urandom_range(0, 8);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // output item check
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_byte(o_m_tdata, o_m_tlast, o_m_tuser);
    end

    // one run item, with an optional gap before it
    task automatic send_run(input logic level, input logic [RUN_W-1:0] run);
        if (s_idle_pct != 0 && $urandom_range(0, 99) < s_idle_pct) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {{(S_DATA_W - RUN_W - 1){1'b0}}, run, level};
        do @(posedge i_clk); while (o_s_tready !== 1'b1);
        sb.note_run(level, run);
        runs_sent++;
    endtask

    // bit sequence to line runs at the polarity the block holds now
    task automatic send_bits(input int glitch_pct);
        int   i;
        int   len;
        logic lvl;
        i = 0;
        while (i < bit_seq.size() && runs_sent < run_limit) begin
            len = 1;
            while (i + len < bit_seq.size() && bit_seq[i+len] == bit_seq[i] &&
                   len < MAX_RUN_DEF)
                len++;
            lvl = bit_seq[i] ^ sb.pol;
            send_run(lvl, RUN_W'(len));
            i += len;
            if ($urandom_range(0, 99) < glitch_pct)
                send_run(1'($urandom_range(0, 1)), '0);
        end
        bit_seq.delete();
    endtask

    // leading part of the sync word, oldest bit first
    task automatic push_sync(input bit inverted, input int nbits);
        for (int k = SYNC_W - 1; k >= SYNC_W - nbits; k--)
            bit_seq.push_back(sb.sync_word[k] ^ inverted);
    endtask

    function automatic logic [BYTE_W-1:0] pick_byte(input int ch);
        if (ch < 3 && $urandom_range(0, 2) == 0) return DROP_BYTE;
        case ($urandom_range(0, 15))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'hF0;
            3:       return 8'h0F;
            4:       return 8'h01;
            5:       return 8'h80;
            6:       return 8'h7F;
            7:       return 8'hFE;
            8:       return DROP_BYTE;
            default: return BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    // sync word then a full or truncated frame of characters
    task automatic send_frame();
        bit                inverted;
        int                cut;
        logic [BYTE_W-1:0] v;
        inverted = $urandom_range(0, 1) && (sb.auto_pol || $urandom_range(0, 3) == 0);
        push_sync(inverted, SYNC_W);
        send_bits(0);
        for (int ch = 0; ch < FRAME_CHARS; ch++) begin
            v = pick_byte(ch);
            bit_seq.push_back($urandom_range(0, 15) == 0);
            for (int k = 0; k < BYTE_W; k++) bit_seq.push_back(v[k]);
            bit_seq.push_back($urandom_range(0, 15) != 0);
        end
        cut = ($urandom_range(0, 9) < 4) ? $urandom_range(1, FRAME_LEN - 1) : FRAME_LEN;
        while (bit_seq.size() > cut) void'(bit_seq.pop_back());
        send_bits($urandom_range(0, 1) ? 0 : 2);
        if (cut < FRAME_LEN) send_run(1'($urandom_range(0, 1)), '0);
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 8))
            send_run(1'($urandom_range(0, 1)), RUN_W'($urandom_range(0, 15)));
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        sb.write_reg(idx, val);
    endtask

    task automatic set_regs(input logic [SYNC_W-1:0] pattern, input logic auto_on,
                            input logic inv_on, input logic [FLUSH_W-1:0] flush_bits);
        cfg_write(CFG_SYNC, CFG_W'(pattern));
        cfg_write(CFG_AUTO, CFG_W'(auto_on));
        cfg_write(CFG_INV, CFG_W'(inv_on));
        cfg_write(CFG_FLUSH, CFG_W'(flush_bits));
        i_cfg_we <= 1'b0;
    endtask

    // hold off until every owed byte is out and the shifter has drained
    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        while (sb.bytes_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        sb = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // all-zero sync word, lowest flush threshold
        set_regs('0, 1'b0, 1'b0, '0);
        send_run(1'b0, 4'd0);
        // twenty zero bits fill the window and match the zero word
        send_run(1'b0, 4'd15);
        send_run(1'b0, 4'd5);
        repeat (21) send_run(1'b1, 4'd15);
        send_run(1'b0, 4'd6);
        // glitch past the floor flushes the padded frame
        send_run(1'b1, 4'd0);
        wait_idle();

        // random phases, each with its own register setting
        for (int p = 0; p < N_PHASES; p++) begin
            if (p == N_PHASES - 1) begin
                s_idle_pct = 0;
                m_idle_pct = 0;
            end else begin
                s_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 50);
                m_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 50);
            end
            case (p)
                0: set_regs(RST_SYNC, 1'b0, 1'b0, RST_FLUSH);
                1: set_regs(SYNC_W'($urandom_range(0, 20'hFFFFF)), 1'b1, 1'b0, 9'd510);
                2: set_regs(20'hFFFFF, 1'b1, 1'b1, 9'd0);
                3: set_regs(SYNC_W'($urandom_range(0, 20'hFFFFF)), 1'b0, 1'b1,
                            FLUSH_W'($urandom_range(320, 509)));
                default: set_regs(RST_SYNC, 1'b1, 1'b0, 9'd319);
            endcase
            run_limit = runs_sent + PHASE_RUNS;
            while (runs_sent < run_limit) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: send_frame();
                    6, 7: send_noise();
                    default: begin
                        // sync word broken off early
                        push_sync(1'b0, $urandom_range(4, SYNC_W - 1));
                        send_bits(0);
                        send_noise();
                    end
                endcase
            end
            wait_idle();
        end

        $display("checked %0d bytes from %0d runs: %0d full frames, %0d glitch flushes,",
                 sb.checked, runs_sent, sb.frames_done, sb.flushes);
        $display("%0d inverted-sync polarity flips, over 6 register settings",
                 sb.syncs_inv);
        if (sb.errors == 0 && sb.bytes_due.size() == 0) begin
            $display("sync_word_8n1_frame_deframer regression: pass");
        end else begin
            $display("sync_word_8n1_frame_deframer regression: fail");
        end
        $finish;
    end

endmodule
